/* hw/rtl/lphw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphw_pkg: shared types and helpers of the LED pixel encoder
// Transaction structs, hue region codes, the divide-by-255 helper and the
// WS2812 three-line-bit expansion.
// ----------------------------------------------------------------------------
package lphw_pkg;

  localparam logic [8:0] HueFull   = 9'd360;
  localparam logic [8:0] HueSector = 9'd60;
  localparam logic [7:0] ChanMax   = 8'd255;
  localparam logic [2:0] LineOne   = 3'b110;
  localparam logic [2:0] LineZero  = 3'b100;

  typedef enum logic {
    OpRgb = 1'b0,
    OpHsv = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    RegionRedYellow    = 3'd0,
    RegionYellowGreen  = 3'd1,
    RegionGreenCyan    = 3'd2,
    RegionCyanBlue     = 3'd3,
    RegionBlueMagenta  = 3'd4,
    RegionMagentaRed   = 3'd5
  } hue_region_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } in_t;

  typedef struct packed {
    logic [23:0] green_line_bits;
    logic [23:0] red_line_bits;
    logic [23:0] blue_line_bits;
  } out_t;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    hue_region_e region;
    logic [7:0]  rem;
    logic [7:0]  sat;
    logic [7:0]  val;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic s1_vld;
    logic s2_vld;
  } bk_stat_t;

  // Exact floor(x / 255) for x below 255 * 256.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + 16'd1 + {8'd0, x[15:8]};
    return sum[15:8];
  endfunction

  // Each data bit becomes three line bits, MSB first.
  function automatic logic [23:0] expand_byte(input logic [7:0] b);
    logic [23:0] word;
    word = '0;
    for (int k = 0; k < 8; k++) begin
      word[3*k +: 3] = b[k] ? LineOne : LineZero;
    end
    return word;
  endfunction

endpackage

/* hw/rtl/lphw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphw_front: pixel intake and hue classification
// Accepts pixel transactions, folds the hue into 0..359, finds its 60 degree
// region and the scaled position inside that region, and holds the result
// until the queue takes it.
// ----------------------------------------------------------------------------
module lphw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lphw_pkg::in_t   in_data_i,
  input  logic            q_full_i,
  output logic            f_valid_o,
  output lphw_pkg::cls_t  f_data_o
);
  import lphw_pkg::*;

  logic        f_vld_q, f_vld_d;
  cls_t        f_data_q, f_data_d;
  logic        in_acc;
  logic [8:0]  h_mod;
  logic [8:0]  h_off;
  hue_region_e region;
  logic [5:0]  pos;
  logic [9:0]  pos_x17;

  assign in_stall_o = f_vld_q && q_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    h_mod = (in_data_i.hue >= HueFull) ? (in_data_i.hue - HueFull) : in_data_i.hue;
    if (h_mod < HueSector) begin
      region = RegionRedYellow;
      h_off  = h_mod;
    end else if (h_mod < HueSector * 9'd2) begin
      region = RegionYellowGreen;
      h_off  = h_mod - HueSector;
    end else if (h_mod < HueSector * 9'd3) begin
      region = RegionGreenCyan;
      h_off  = h_mod - HueSector * 9'd2;
    end else if (h_mod < HueSector * 9'd4) begin
      region = RegionCyanBlue;
      h_off  = h_mod - HueSector * 9'd3;
    end else if (h_mod < HueSector * 9'd5) begin
      region = RegionBlueMagenta;
      h_off  = h_mod - HueSector * 9'd4;
    end else begin
      region = RegionMagentaRed;
      h_off  = h_mod - HueSector * 9'd5;
    end
    pos = h_off[5:0];
    // 255 / 60 is 17 / 4, so the scaled position is (pos * 17) >> 2.
    pos_x17 = {pos, 4'd0} + {4'd0, pos};

    f_data_d.opcode = in_data_i.opcode;
    f_data_d.red    = in_data_i.red;
    f_data_d.green  = in_data_i.green;
    f_data_d.blue   = in_data_i.blue;
    f_data_d.region = region;
    f_data_d.rem    = pos_x17[9:2];
    f_data_d.sat    = in_data_i.saturation;
    f_data_d.val    = in_data_i.brightness;
  end

  always_comb begin
    if (in_acc) begin
      f_vld_d = 1'b1;
    end else if (!q_full_i) begin
      f_vld_d = 1'b0;
    end else begin
      f_vld_d = f_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= f_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_data_q <= f_data_d;
    end
  end

  assign f_valid_o = f_vld_q;
  assign f_data_o  = f_data_q;

endmodule

/* hw/rtl/lphw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphw_queue: short queue between front and back end
// Register-based FIFO of classified pixels. A push is refused while full.
// ----------------------------------------------------------------------------
module lphw_queue #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lphw_pkg::cls_t    data_i,
  input  logic              pop_i,
  output lphw_pkg::cls_t    data_o,
  output lphw_pkg::q_stat_t status_o
);
  import lphw_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cls_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, empty, do_push, do_pop;

  assign full    = (cnt_q == CntW'(Depth));
  assign empty   = (cnt_q == '0);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = full;
  assign status_o.empty = empty;

endmodule

/* hw/rtl/lphw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphw_back: HSV arithmetic and line-bit expansion
// Three pipeline stages: first products, scaled intermediates with second
// products, then region select, expansion and the output register.
// ----------------------------------------------------------------------------
module lphw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               take_o,
  input  lphw_pkg::cls_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lphw_pkg::out_t     out_data_o,
  output lphw_pkg::bk_stat_t status_o
);
  import lphw_pkg::*;

  // Stage 1 registers.
  logic        s1_vld_q;
  opcode_e     s1_op_q;
  hue_region_e s1_reg_q;
  logic [7:0]  s1_r_q, s1_g_q, s1_b_q, s1_v_q;
  logic [15:0] s1_pp_q, s1_sr_q, s1_st_q;
  // Stage 2 registers.
  logic        s2_vld_q;
  opcode_e     s2_op_q;
  hue_region_e s2_reg_q;
  logic [7:0]  s2_r_q, s2_g_q, s2_b_q, s2_v_q, s2_p_q;
  logic [15:0] s2_mq_q, s2_mt_q;
  // Output registers.
  logic        s3_vld_q;
  out_t        s3_data_q;

  logic        rdy1, rdy2, rdy3;
  logic [7:0]  qm, tm, q_val, t_val;
  logic [7:0]  sel_r, sel_g, sel_b;

  assign rdy3   = !s3_vld_q || !out_stall_i;
  assign rdy2   = !s2_vld_q || rdy3;
  assign rdy1   = !s1_vld_q || rdy2;
  assign take_o = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_vld_q <= in_valid_i;
      end
      if (rdy2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (rdy3) begin
        s3_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      s1_op_q  <= in_data_i.opcode;
      s1_reg_q <= in_data_i.region;
      s1_r_q   <= in_data_i.red;
      s1_g_q   <= in_data_i.green;
      s1_b_q   <= in_data_i.blue;
      s1_v_q   <= in_data_i.val;
      s1_pp_q  <= 16'(in_data_i.val) * 16'(ChanMax - in_data_i.sat);
      s1_sr_q  <= 16'(in_data_i.sat) * 16'(in_data_i.rem);
      s1_st_q  <= 16'(in_data_i.sat) * 16'(ChanMax - in_data_i.rem);
    end
  end

  assign qm = ChanMax - div255(s1_sr_q);
  assign tm = ChanMax - div255(s1_st_q);

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && rdy2) begin
      s2_op_q  <= s1_op_q;
      s2_reg_q <= s1_reg_q;
      s2_r_q   <= s1_r_q;
      s2_g_q   <= s1_g_q;
      s2_b_q   <= s1_b_q;
      s2_v_q   <= s1_v_q;
      s2_p_q   <= div255(s1_pp_q);
      s2_mq_q  <= 16'(s1_v_q) * 16'(qm);
      s2_mt_q  <= 16'(s1_v_q) * 16'(tm);
    end
  end

  assign q_val = div255(s2_mq_q);
  assign t_val = div255(s2_mt_q);

  always_comb begin
    case (s2_reg_q)
      RegionRedYellow: begin
        sel_r = s2_v_q; sel_g = t_val;  sel_b = s2_p_q;
      end
      RegionYellowGreen: begin
        sel_r = q_val;  sel_g = s2_v_q; sel_b = s2_p_q;
      end
      RegionGreenCyan: begin
        sel_r = s2_p_q; sel_g = s2_v_q; sel_b = t_val;
      end
      RegionCyanBlue: begin
        sel_r = s2_p_q; sel_g = q_val;  sel_b = s2_v_q;
      end
      RegionBlueMagenta: begin
        sel_r = t_val;  sel_g = s2_p_q; sel_b = s2_v_q;
      end
      default: begin
        sel_r = s2_v_q; sel_g = s2_p_q; sel_b = q_val;
      end
    endcase
    if (s2_op_q == OpRgb) begin
      sel_r = s2_r_q;
      sel_g = s2_g_q;
      sel_b = s2_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && rdy3) begin
      s3_data_q.green_line_bits <= expand_byte(sel_g);
      s3_data_q.red_line_bits   <= expand_byte(sel_r);
      s3_data_q.blue_line_bits  <= expand_byte(sel_b);
    end
  end

  assign out_valid_o     = s3_vld_q;
  assign out_data_o      = s3_data_q;
  assign status_o.s1_vld = s1_vld_q;
  assign status_o.s2_vld = s2_vld_q;

endmodule

/* hw/rtl/led_pixel_hsv_ws2812_encoder_top.sv */
`timescale 1ns / 1ps
// Path: an accepted pixel passes the front register, the queue, stage 1, stage 2 and the output register.
// Throughput: one pixel per clock while the output is not stalled, set by the fully pipelined back end.
// Stalls: the queue of QueueDepth entries lets the intake keep accepting while
//   the output is stalled, until the queue and the pipeline stages are full.
// Reset: asynchronous, active low; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// led_pixel_hsv_ws2812_encoder_top: WS2812 pixel encoder with HSV input
// Converts RGB or HSV pixels into three 24-bit line words (G, R, B).
// ----------------------------------------------------------------------------
module led_pixel_hsv_ws2812_encoder_top #(
  parameter int QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lphw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lphw_pkg::out_t out_data_o
);
  import lphw_pkg::*;

  // The front end registers each incoming transaction after folding the hue
  // into range and locating its sector. It only stalls when it holds an item
  // and the queue cannot take it.
  logic     f_vld;
  cls_t     f_data;
  q_stat_t  q_stat;
  cls_t     q_data;
  logic     bk_take;
  bk_stat_t bk_stat;

  lphw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_stat.full),
    .f_valid_o  (f_vld),
    .f_data_o   (f_data)
  );

  // The queue decouples intake from the arithmetic pipeline so that each side
  // can be held independently.
  lphw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (f_vld),
    .data_i   (f_data),
    .pop_i    (bk_take),
    .data_o   (q_data),
    .status_o (q_stat)
  );

  // The back end computes p, q and t over two multiply stages, picks the
  // channel values by sector, expands them to line bits and holds the result
  // in the output register. RGB transactions pass straight through.
  lphw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_stat.empty),
    .take_o      (bk_take),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_o    (bk_stat)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction is always held in the front register next cycle.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> f_vld)
    else $error("accepted transaction not captured by the front end");

  // A front item blocked by a full queue is kept, unchanged.
  a_front_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_vld && q_stat.full) |=> (f_vld && $stable(f_data)))
    else $error("front item lost while the queue was full");

  // New output data only comes from an item in the last arithmetic stage.
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.s2_vld))
    else $error("output valid without a preceding pipeline item");
`endif

endmodule

/* bench/tb_led_pixel_hsv_ws2812_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_pixel_hsv_ws2812_encoder_top: self-checking bench of the pixel encoder
// Feeds RGB and HSV pixels through the valid/stall intake, predicts the three
// WS2812 line words of every accepted pixel and checks them in order at the
// output, under random idling on both sides and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_led_pixel_hsv_ws2812_encoder_top;

  import lphw_pkg::*;

  // The run is ended by force after this many clock cycles. A correct run of
  // about 1500 pixels with 8% idling and two long hold-offs ends well before
  // this limit.
  localparam int unsigned CycleLimit  = 200000;
  // Cycles the output side holds off when a back-pressure stretch is asked for.
  localparam int unsigned HoldOffLen  = 48;
  // Extra settling at the end, after every expected result has come out.
  localparam int unsigned SettleLen   = 8;

  // --------------------------------------------------------------------------
  // Expected line words of accepted pixels, with the bench's own prediction.
  // --------------------------------------------------------------------------
  class line_word_scoreboard;
    out_t        expected_words[$];
    int unsigned mismatch_count;
    int unsigned words_checked;
    int unsigned rgb_count;
    int unsigned hsv_count;
    int unsigned grey_count;

    function new();
      mismatch_count = 0;
      words_checked  = 0;
      rgb_count      = 0;
      hsv_count      = 0;
      grey_count     = 0;
    endfunction

    // Each data bit, MSB first, becomes three line bits: 110 for a one and
    // 100 for a zero.
    function logic [23:0] line_bits(logic [7:0] data_byte);
      logic [23:0] word;
      word = '0;
      for (int k = 7; k >= 0; k--) begin
        word = {word[20:0], data_byte[k] ? LineOne : LineZero};
      end
      return word;
    endfunction

    // Integer HSV conversion over six 60-degree sectors, then expansion of
    // the colour bytes in wire order green, red, blue.
    function out_t encode_pixel(in_t px);
      int unsigned red_v, green_v, blue_v;
      int unsigned h, s, v, frac, p, q, t;
      hue_region_e sector;
      out_t        words;
      if (px.opcode == OpRgb) begin
        red_v   = px.red;
        green_v = px.green;
        blue_v  = px.blue;
      end else if (px.saturation == 8'd0) begin
        // No saturation means grey at the brightness level, whatever the hue.
        red_v   = px.brightness;
        green_v = px.brightness;
        blue_v  = px.brightness;
      end else begin
        s      = px.saturation;
        v      = px.brightness;
        h      = px.hue % HueFull;
        sector = hue_region_e'(3'(h / HueSector));
        frac   = ((h % HueSector) * ChanMax) / HueSector;
        p      = (v * (ChanMax - s)) / ChanMax;
        q      = (v * (ChanMax - (s * frac) / ChanMax)) / ChanMax;
        t      = (v * (ChanMax - (s * (ChanMax - frac)) / ChanMax)) / ChanMax;
        case (sector)
          RegionRedYellow: begin
            red_v = v; green_v = t; blue_v = p;
          end
          RegionYellowGreen: begin
            red_v = q; green_v = v; blue_v = p;
          end
          RegionGreenCyan: begin
            red_v = p; green_v = v; blue_v = t;
          end
          RegionCyanBlue: begin
            red_v = p; green_v = q; blue_v = v;
          end
          RegionBlueMagenta: begin
            red_v = t; green_v = p; blue_v = v;
          end
          default: begin
            red_v = v; green_v = p; blue_v = q;
          end
        endcase
      end
      words.green_line_bits = line_bits(green_v[7:0]);
      words.red_line_bits   = line_bits(red_v[7:0]);
      words.blue_line_bits  = line_bits(blue_v[7:0]);
      return words;
    endfunction

    function void note_pixel(in_t px);
      if (px.opcode == OpRgb) begin
        rgb_count++;
      end else begin
        hsv_count++;
        if (px.saturation == 8'd0) begin
          grey_count++;
        end
      end
      expected_words.push_back(encode_pixel(px));
    endfunction

    function void compare_word(string label, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %06h actual %06h", $time, label, want, got);
      end
    endfunction

    function void check_words(out_t seen);
      out_t want;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output, expected nothing actual %h", $time, seen);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      compare_word("green_line_bits", want.green_line_bits, seen.green_line_bits);
      compare_word("red_line_bits", want.red_line_bits, seen.red_line_bits);
      compare_word("blue_line_bits", want.blue_line_bits, seen.blue_line_bits);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  line_word_scoreboard board;

  // Random idling of both sides is switched off for the quiet stretch.
  logic        idle_enable;
  // Each increment asks the output side for one long hold-off.
  int unsigned holdoff_requests;
  int unsigned holdoff_served;
  int unsigned holdoff_left;
  int unsigned cycle_count;
  int unsigned intake_blocked_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  led_pixel_hsv_ws2812_encoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Output side. Every transaction taken at this edge is checked against the
  // oldest expectation, then the stall for the next cycle is chosen. Values
  // read here are those from before the edge, since the block's registers and
  // this bench's drivers update only in the nonblocking region.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_words(out_data_o);
    end
    if (holdoff_requests != holdoff_served) begin
      holdoff_served = holdoff_requests;
      holdoff_left   = HoldOffLen;
    end
    if (holdoff_left > 0) begin
      // Long back-pressure: the block must fill its queue and stall its intake.
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_enable && ($urandom_range(99) < 8);
    end
  end

  // Watchdog and a count of cycles in which the intake pushed back.
  always @(posedge clk_i) begin
    cycle_count++;
    if (in_valid_i && in_stall_o) begin
      intake_blocked_cycles++;
    end
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, board.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Offers one pixel and returns at the edge where it was accepted. Valid stays
  // high on return, so back-to-back pixels never drop it within a time step.
  task automatic send_pixel(input in_t px);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    board.note_pixel(px);
  endtask

  // Drops valid for the given number of cycles; the payload is scrambled to show
  // that the block ignores it while valid is low.
  task automatic sender_pause(input int unsigned cycles);
    in_valid_i <= 1'b0;
    in_data_i  <= in_t'({$urandom, $urandom});
    repeat (cycles) @(posedge clk_i);
  endtask

  // Random idling of the sender between transactions. After about three pixels
  // in a hundred, valid drops for a random pause.
  task automatic maybe_idle();
    if (idle_enable && ($urandom_range(99) < 3)) begin
      sender_pause($urandom_range(1, 4));
    end
  endtask

  // Holds the sender until every expected result has come out.
  task automatic wait_drained();
    sender_pause(1);
    while (board.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic in_t random_pixel();
    in_t         px;
    int unsigned pick;
    px.opcode = opcode_e'(1'($urandom_range(1)));
    px.red    = 8'($urandom);
    px.green  = 8'($urandom);
    px.blue   = 8'($urandom);
    px.hue    = 9'($urandom);
    // Saturation and brightness lean toward their extremes now and then, so
    // grey pixels and full-scale corners turn up often.
    pick = $urandom_range(9);
    px.saturation = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    pick = $urandom_range(9);
    px.brightness = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    return px;
  endfunction

  task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_t px;
    px            = random_pixel();
    px.opcode     = OpRgb;
    px.red        = r;
    px.green      = g;
    px.blue       = b;
    send_pixel(px);
    maybe_idle();
  endtask

  task automatic send_hsv(input logic [8:0] h, input logic [7:0] s, input logic [7:0] v);
    in_t px;
    px            = random_pixel();
    px.opcode     = OpHsv;
    px.hue        = h;
    px.saturation = s;
    px.brightness = v;
    send_pixel(px);
    maybe_idle();
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_pixel(random_pixel());
      maybe_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned failures;
    board                 = new();
    holdoff_requests      = 0;
    holdoff_served        = 0;
    holdoff_left          = 0;
    cycle_count           = 0;
    intake_blocked_cycles = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    out_stall_i  <= 1'b0;
    idle_enable  <= 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels: channel extremes and alternating bit patterns in RGB
    // form, then every sector boundary of the hue circle at full saturation.
    send_rgb(8'h00, 8'h00, 8'h00);
    send_rgb(8'hFF, 8'hFF, 8'hFF);
    send_rgb(8'hAA, 8'h55, 8'h0F);
    send_rgb(8'h01, 8'h80, 8'hFE);
    for (int sector_edge = 0; sector_edge < 6; sector_edge++) begin
      send_hsv(9'(sector_edge * 60), 8'd255, 8'd255);
      send_hsv(9'(sector_edge * 60 + 59), 8'd255, 8'd255);
    end
    // Hues of 360 and above wrap around before the sector is chosen.
    send_hsv(9'd360, 8'd200, 8'd180);
    send_hsv(9'd419, 8'd128, 8'd77);
    send_hsv(9'd511, 8'd255, 8'd255);
    // Zero saturation gives grey, regardless of hue.
    send_hsv(9'd123, 8'd0, 8'd200);
    send_hsv(9'd511, 8'd0, 8'd255);
    // Black, barely saturated and barely lit pixels.
    send_hsv(9'd200, 8'd255, 8'd0);
    send_hsv(9'd30, 8'd1, 8'd255);
    send_hsv(9'd330, 8'd255, 8'd1);
    wait_drained();

    // Random pixels with idling on both sides.
    send_random(500);

    // Quiet stretch: no idling at all, and a long output hold-off while the
    // sender keeps offering pixels, so the block fills and stalls its intake.
    idle_enable      <= 1'b0;
    holdoff_requests <= holdoff_requests + 1;
    send_random(300);

    // The sender waits for every result before going on.
    wait_drained();

    idle_enable <= 1'b1;
    send_random(350);
    holdoff_requests <= holdoff_requests + 1;
    send_random(350);

    wait_drained();
    repeat (SettleLen) @(posedge clk_i);

    failures = board.mismatch_count + board.pending();
    $display("Pixels sent: %0d RGB, %0d HSV (%0d grey); %0d results checked",
             board.rgb_count, board.hsv_count, board.grey_count, board.words_checked);
    $display("Intake held back for %0d cycles under output back-pressure",
             intake_blocked_cycles);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
